### src/trw_pkg.sv
// Shared codes, constants and word types of the trie root word replacer.
package trw_pkg;

	// Command codes on the input channel.
	localparam logic [2:0] CMD_CLEAR    = 3'd0;
	localparam logic [2:0] CMD_LETTER   = 3'd1;
	localparam logic [2:0] CMD_WORD_END = 3'd2;
	localparam logic [2:0] CMD_BYTE     = 3'd3;
	localparam logic [2:0] CMD_END      = 3'd4;

	// Classified operations handed from the front to the back.
	localparam logic [2:0] OP_CLEAR      = 3'd0;
	localparam logic [2:0] OP_LETTER     = 3'd1;
	localparam logic [2:0] OP_LETTER_BAD = 3'd2;
	localparam logic [2:0] OP_WORD_END   = 3'd3;
	localparam logic [2:0] OP_SPACE      = 3'd4;
	localparam logic [2:0] OP_BYTE       = 3'd5;
	localparam logic [2:0] OP_DONE       = 3'd6;

	// Status codes on the result channel.
	localparam logic [1:0] STAT_OK         = 2'd0;
	localparam logic [1:0] STAT_FULL       = 2'd1;
	localparam logic [1:0] STAT_BAD_LETTER = 2'd2;

	// Character constants.
	localparam logic [7:0] CH_A     = 8'd97;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam int         LETTERS  = 26;

	// Branch index width, enough for the largest alphabet.
	localparam int BR_W = 5;

	// Word carried by the queue between front and back.
	typedef struct packed {
		logic [2:0]      op;
		logic [7:0]      letter;
		logic [BR_W-1:0] br;
		logic            br_ok;
	} op_word_t;

	// Word carried by the result queue.
	typedef struct packed {
		logic [7:0] out_char;
		logic       done;
		logic [1:0] status;
	} res_word_t;

endpackage

### src/trw_ram.sv
// Generic single write port, single read port RAM with registered read data.
module trw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/trw_fifo.sv
// Small register queue used between the front and back and on the result side.
module trw_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic [W-1:0] dout,
	output logic         empty
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wr_q;
	logic [PW-1:0] rd_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

### src/trw_front.sv
// Front end: accepts input words and classifies them into back-end operations.
module trw_front import trw_pkg::*; #(
	parameter int ALPHABET = 26
) (
	input  logic       push,
	output logic       full,
	input  logic [2:0] cmd,
	input  logic [7:0] letter,
	input  logic       q_full,
	output logic       q_push,
	output op_word_t   q_word
);

	localparam int LIMIT = (ALPHABET < LETTERS) ? ALPHABET : LETTERS;

	logic [7:0] offs;
	logic       br_ok;
	logic       useful;
	logic [2:0] op;

	// Branch index of the byte and whether it has a branch at all.
	assign offs  = letter - CH_A;
	assign br_ok = (letter >= CH_A) && (offs < 8'(LIMIT));

	// Command decode; unused command codes are accepted and dropped.
	always_comb begin
		useful = 1'b1;
		op     = OP_CLEAR;
		unique case (cmd)
			CMD_CLEAR:    op = OP_CLEAR;
			CMD_LETTER:   op = br_ok ? OP_LETTER : OP_LETTER_BAD;
			CMD_WORD_END: op = OP_WORD_END;
			CMD_BYTE:     op = (letter == CH_SPACE) ? OP_SPACE : OP_BYTE;
			CMD_END:      op = OP_DONE;
			default:      useful = 1'b0;
		endcase
	end

	assign full          = q_full;
	assign q_push        = push && !q_full && useful;
	assign q_word.op     = op;
	assign q_word.letter = letter;
	assign q_word.br     = offs[BR_W-1:0];
	assign q_word.br_ok  = br_ok;

endmodule

### src/trw_back.sv
// Back end: walks and grows the trie held in the node memories, one operation at a time.
module trw_back import trw_pkg::*; #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  op_word_t  q_word,
	output logic      q_pop,
	input  logic      out_full,
	output logic      res_push,
	output res_word_t res_word
);

	localparam int NODE_W    = $clog2(NODES);
	localparam int USED_W    = $clog2(NODES + 1);
	localparam int SLOT_W    = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
	localparam int PTR_DEPTH = NODES * (1 << SLOT_W);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_EXEC  = 2'd1;
	localparam logic [1:0] S_ALLOC = 2'd2;

	logic [1:0]          state_q;
	op_word_t            item_s1;
	logic [NODE_W-1:0]   cur_s1;
	logic [NODE_W-1:0]   alloc_q;
	logic [NODE_W-1:0]   ins_q;
	logic [NODE_W-1:0]   match_q;
	logic [USED_W-1:0]   used_q;
	logic                walking_q;
	logic                supp_q;
	logic [ALPHABET-1:0] root_pres_q;
	logic                root_end_q;

	logic                issue;
	logic                exec;
	logic [NODE_W-1:0]   node_rd;
	logic [SLOT_W-1:0]   slot;
	logic [ALPHABET-1:0] bit_oh;
	logic [ALPHABET-1:0] pres_rd;
	logic [ALPHABET-1:0] pres_cur;
	logic                end_rd;
	logic                end_cur;
	logic [NODE_W-1:0]   ptr_rd;
	logic                hit;
	logic                has_room;
	logic                letter_alloc;
	logic [NODE_W-1:0]   new_node;

	logic                pres_we;
	logic [NODE_W-1:0]   pres_waddr;
	logic [ALPHABET-1:0] pres_wdata;
	logic                end_we;
	logic [NODE_W-1:0]   end_waddr;
	logic                end_wdata;
	logic                ptr_we;

	// Issue a word when the sequencer is idle, one waits and the result queue has room for its result.
	assign issue   = (state_q == S_IDLE) && !q_empty && !out_full;
	assign exec    = (state_q == S_EXEC);
	assign q_pop   = issue;
	assign node_rd = (q_word.op == OP_LETTER) ? ins_q : match_q;

	// Node memories; the root lives in registers so that reset clears it.
	trw_ram #(.WIDTH(ALPHABET), .DEPTH(NODES)) u_pres_ram (
		.clk   (clk),
		.we    (pres_we),
		.waddr (pres_waddr),
		.wdata (pres_wdata),
		.raddr (node_rd),
		.rdata (pres_rd)
	);

	trw_ram #(.WIDTH(1), .DEPTH(NODES)) u_end_ram (
		.clk   (clk),
		.we    (end_we),
		.waddr (end_waddr),
		.wdata (end_wdata),
		.raddr (node_rd),
		.rdata (end_rd)
	);

	trw_ram #(.WIDTH(NODE_W), .DEPTH(PTR_DEPTH)) u_ptr_ram (
		.clk   (clk),
		.we    (ptr_we),
		.waddr ({cur_s1, slot}),
		.wdata (new_node),
		.raddr ({node_rd, q_word.br[SLOT_W-1:0]}),
		.rdata (ptr_rd)
	);

	// Branch lookup at the node that the word was issued against.
	assign slot         = item_s1.br[SLOT_W-1:0];
	assign bit_oh       = ALPHABET'(1) << slot;
	assign pres_cur     = (cur_s1 == '0) ? root_pres_q : pres_rd;
	assign end_cur      = (cur_s1 == '0) ? root_end_q : end_rd;
	assign hit          = item_s1.br_ok && ((pres_cur & bit_oh) != '0);
	assign has_room     = (used_q < USED_W'(NODES));
	assign new_node     = used_q[NODE_W-1:0];
	assign letter_alloc = exec && (item_s1.op == OP_LETTER) && !hit && has_room;

	// Memory writes: link a new node, then clear its branch mask in the next cycle; a word end marks its node.
	always_comb begin
		pres_we    = 1'b0;
		pres_waddr = cur_s1;
		pres_wdata = pres_cur | bit_oh;
		end_we     = 1'b0;
		end_waddr  = new_node;
		end_wdata  = 1'b0;
		ptr_we     = letter_alloc;
		if (letter_alloc) begin
			pres_we = (cur_s1 != '0);
			end_we  = 1'b1;
		end else if (state_q == S_ALLOC) begin
			pres_we    = 1'b1;
			pres_waddr = alloc_q;
			pres_wdata = '0;
		end else if (exec && (item_s1.op == OP_WORD_END) && (ins_q != '0)) begin
			end_we    = 1'b1;
			end_waddr = ins_q;
			end_wdata = 1'b1;
		end
	end

	// Result word of the operation in execution.
	always_comb begin
		res_push = 1'b0;
		res_word = '0;
		if (exec) begin
			unique case (item_s1.op)
				OP_LETTER: begin
					if (!hit && !has_room) begin
						res_push        = 1'b1;
						res_word.status = STAT_FULL;
					end
				end
				OP_LETTER_BAD: begin
					res_push        = 1'b1;
					res_word.status = STAT_BAD_LETTER;
				end
				OP_SPACE: begin
					res_push          = 1'b1;
					res_word.out_char = item_s1.letter;
				end
				OP_BYTE: begin
					if (!supp_q && !(walking_q && end_cur)) begin
						res_push          = 1'b1;
						res_word.out_char = item_s1.letter;
					end
				end
				OP_DONE: begin
					res_push      = 1'b1;
					res_word.done = 1'b1;
				end
				default: res_push = 1'b0;
			endcase
		end
	end

	// Sequencer and trie state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ins_q       <= '0;
			match_q     <= '0;
			used_q      <= USED_W'(1);
			walking_q   <= 1'b1;
			supp_q      <= 1'b0;
			root_pres_q <= '0;
			root_end_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (issue) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= letter_alloc ? S_ALLOC : S_IDLE;
					unique case (item_s1.op)
						OP_CLEAR: begin
							root_pres_q <= '0;
							root_end_q  <= 1'b0;
							used_q      <= USED_W'(1);
							ins_q       <= '0;
							match_q     <= '0;
							walking_q   <= 1'b1;
							supp_q      <= 1'b0;
						end
						OP_LETTER: begin
							if (hit) begin
								ins_q <= ptr_rd;
							end else if (has_room) begin
								if (cur_s1 == '0) begin
									root_pres_q <= root_pres_q | bit_oh;
								end
								ins_q  <= new_node;
								used_q <= used_q + 1'b1;
							end
						end
						OP_WORD_END: begin
							if (ins_q == '0) begin
								root_end_q <= 1'b1;
							end
							ins_q <= '0;
						end
						OP_SPACE, OP_DONE: begin
							match_q   <= '0;
							walking_q <= 1'b1;
							supp_q    <= 1'b0;
						end
						OP_BYTE: begin
							if (!supp_q && walking_q) begin
								if (end_cur) begin
									walking_q <= 1'b0;
									supp_q    <= 1'b1;
								end else if (hit) begin
									match_q <= ptr_rd;
								end else begin
									walking_q <= 1'b0;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_ALLOC: state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Operation registers of the word in execution.
	always_ff @(posedge clk) begin
		if (issue) begin
			item_s1 <= q_word;
			cur_s1  <= node_rd;
		end
		if (letter_alloc) begin
			alloc_q <= new_node;
		end
	end

endmodule

### src/trie_root_word_replacer_unit.sv
// Top level of the trie root word replacer: front, queues and back end.
//
//   Channel   Handshake            Fields
//   input     push / full          cmd, letter
//   result    empty / pop          out_char, sentence_done, status
//
// The back end finishes each queued word before it takes the next. It first reads
// the node memories at the current cursor, then updates the trie or walk state and
// writes the result. A dictionary letter that allocates a node also passes through
// S_ALLOC to clear the new node's branch mask. Unused command codes are accepted
// and dropped in the front. Reset clears the root in registers; no memory clearing
// pass is needed. Two-entry queues sit between front and back and before the result
// ports, which absorb a stall on either side until one of them fills.
module trie_root_word_replacer_unit import trw_pkg::*; #(
	parameter int NODES    = 1024,
	parameter int ALPHABET = 26
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [2:0] cmd,
	input  logic [7:0] letter,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       sentence_done,
	output logic [1:0] status
);

	logic      mq_full;
	logic      mq_push;
	op_word_t  mq_din;
	logic      mq_empty;
	logic      mq_pop;
	op_word_t  mq_dout;
	logic      rq_full;
	logic      rq_push;
	res_word_t rq_din;
	res_word_t rq_dout;

	// Classification of incoming words.
	trw_front #(.ALPHABET(ALPHABET)) u_front (
		.push   (push),
		.full   (full),
		.cmd    (cmd),
		.letter (letter),
		.q_full (mq_full),
		.q_push (mq_push),
		.q_word (mq_din)
	);

	// Queue of classified operations.
	trw_fifo #(.W($bits(op_word_t)), .DEPTH(2)) u_op_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (mq_push),
		.din    (mq_din),
		.full   (mq_full),
		.pop    (mq_pop),
		.dout   (mq_dout),
		.empty  (mq_empty)
	);

	// Trie engine.
	trw_back #(.NODES(NODES), .ALPHABET(ALPHABET)) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (mq_empty),
		.q_word   (mq_dout),
		.q_pop    (mq_pop),
		.out_full (rq_full),
		.res_push (rq_push),
		.res_word (rq_din)
	);

	// Result queue in front of the output ports.
	trw_fifo #(.W($bits(res_word_t)), .DEPTH(2)) u_res_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (rq_push),
		.din    (rq_din),
		.full   (rq_full),
		.pop    (pop),
		.dout   (rq_dout),
		.empty  (empty)
	);

	assign out_char      = rq_dout.out_char;
	assign sentence_done = rq_dout.done;
	assign status        = rq_dout.status;

endmodule
